// ===== src/quad_corner_normals_macros.svh =====
// Assertion macros for the checker file.
`ifndef QUAD_CORNER_NORMALS_MACROS_SVH
`define QUAD_CORNER_NORMALS_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define QCN_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define QCN_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== src/qcn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcn_pkg
// Shared constants for the quad corner normal block.
// ----------------------------------------------------------------------------
package qcn_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    localparam int OUT_W      = 16;
    localparam int NUM_CORNERS = 4;
    localparam int CORNER_W   = 2;
    localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

    // Normalized component magnitudes live in [0, 2^31).
    localparam int MAG_W  = 31;
    // Sum of three squares of 31 bit values stays below 2^64.
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;

endpackage

// ===== src/quad_corner_normals.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_corner_normals
// Per-corner unit normals of a quad from the cross products of adjacent edges.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_v1_x .. i_v4_z
//  output    out        o_valid / i_ready    o_corner, o_normal_*, o_degenerate, o_last
//
// A quad is taken and then walked through its four corners, one corner per cycle
// while the output is not stalled; the next quad is accepted while the last corner is walked.
// Each corner passes a pipeline of 56 register stages (cross product, alignment,
// square root and divider, one bit per stage); the corners of a quad leave in
// order, corner 0 first and corner 3 last.
// The whole pipeline advances together; it freezes while the output register
// holds a result that is not taken, so a stall loses or repeats nothing.
// Reset clears the valid bits and the corner walk only.
// ----------------------------------------------------------------------------
module quad_corner_normals #(
    parameter int COORD_WIDTH      = qcn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = qcn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [15:0] i_v1_x,
    input  logic signed [15:0] i_v1_y,
    input  logic signed [15:0] i_v1_z,
    input  logic signed [15:0] i_v2_x,
    input  logic signed [15:0] i_v2_y,
    input  logic signed [15:0] i_v2_z,
    input  logic signed [15:0] i_v3_x,
    input  logic signed [15:0] i_v3_y,
    input  logic signed [15:0] i_v3_z,
    input  logic signed [15:0] i_v4_x,
    input  logic signed [15:0] i_v4_y,
    input  logic signed [15:0] i_v4_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_corner,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic        o_degenerate,
    output logic        o_last
);

    localparam int EW = (COORD_WIDTH > 29) ? 30 : COORD_WIDTH + 1;
    localparam int CW = 2 * EW + 2;
    localparam int IW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;

    // Coordinates held for the four-corner walk.
    logic signed [COORD_WIDTH-1:0] r_p [4][3];
    logic                          r_busy;
    logic [1:0]                    r_k;
    logic                          w_en;
    logic                          w_take;

    logic signed [COORD_WIDTH-1:0] w_a [3];
    logic signed [COORD_WIDTH-1:0] w_b [3];
    logic signed [COORD_WIDTH-1:0] w_c [3];
    logic signed [CW-1:0]          w_cross [3];
    // Corner index delayed alongside the two cross product stages.
    logic                          r_v1, r_v2;
    logic [1:0]                    r_k1, r_k2;

    logic                          w_nv;
    logic [1:0]                    w_nk;
    logic signed [15:0]            w_n [3];
    logic                          w_nd;

    // A coordinate wider than the port takes the port bits without sign extension.
    function automatic logic signed [COORD_WIDTH-1:0] sx(input logic [15:0] v);
        if (COORD_WIDTH > 16) begin
            sx = COORD_WIDTH'($unsigned(v));
        end else begin
            sx = COORD_WIDTH'($signed(v[IW-1:0]));
        end
    endfunction

    assign w_en   = !o_valid || i_ready;
    assign o_ready = w_en && (!r_busy || r_k == qcn_pkg::CORNER_LAST);
    assign w_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else if (w_en) begin
            r_v1 <= r_busy;
            r_k1 <= r_k;
            r_v2 <= r_v1;
            r_k2 <= r_k1;
            if (w_take) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_busy <= (r_k != qcn_pkg::CORNER_LAST);
                r_k    <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_p[0] <= '{sx(i_v1_x), sx(i_v1_y), sx(i_v1_z)};
            r_p[1] <= '{sx(i_v2_x), sx(i_v2_y), sx(i_v2_z)};
            r_p[2] <= '{sx(i_v3_x), sx(i_v3_y), sx(i_v3_z)};
            r_p[3] <= '{sx(i_v4_x), sx(i_v4_y), sx(i_v4_z)};
        end
    end

    // Corner k: u = p(k-1) - p(k), v = p(k) - p(k+1); u x v.
    always_comb begin
        w_a = r_p[r_k - 2'd1];
        w_b = r_p[r_k];
        w_c = r_p[r_k + 2'd1];
    end

    qcn_cross #(.COORD_WIDTH(COORD_WIDTH), .EW(EW), .CW(CW)) u_cross (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .o_cross (w_cross)
    );

    qcn_norm #(.CW(CW), .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (r_v2),
        .i_corner     (r_k2),
        .i_cross      (w_cross),
        .o_valid      (w_nv),
        .o_corner     (w_nk),
        .o_normal     (w_n),
        .o_degenerate (w_nd)
    );

    assign o_valid      = w_nv;
    assign o_corner     = w_nk;
    assign o_normal_x   = w_n[0];
    assign o_normal_y   = w_n[1];
    assign o_normal_z   = w_n[2];
    assign o_degenerate = w_nd;
    assign o_last       = (w_nk == qcn_pkg::CORNER_LAST);

endmodule

// ===== src/qcn_cross.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcn_cross
// Edge subtraction and cross product for one corner, two register stages.
// ----------------------------------------------------------------------------
module qcn_cross #(
    parameter int COORD_WIDTH = qcn_pkg::COORD_WIDTH_DEF,
    parameter int EW = (COORD_WIDTH > 29) ? 30 : COORD_WIDTH + 1,
    parameter int CW = 2 * EW + 2
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_a [3],
    input  logic signed [COORD_WIDTH-1:0] i_b [3],
    input  logic signed [COORD_WIDTH-1:0] i_c [3],
    output logic signed [CW-1:0]          o_cross [3]
);

    localparam int EDGE_SHIFT = (COORD_WIDTH > 29) ? COORD_WIDTH - 29 : 0;
    localparam int PW = 2 * EW;

    // Edges u = a - b and v = b - c; the corner normal is u x v.
    logic signed [EW-1:0] r_u [3];
    logic signed [EW-1:0] r_v [3];
    logic signed [EW-1:0] n_u [3];
    logic signed [EW-1:0] n_v [3];
    logic signed [PW-1:0] r_p [6];
    logic signed [PW-1:0] n_p [6];

    function automatic logic signed [EW-1:0] edge_of(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] d;
        logic        [COORD_WIDTH:0] m;
        begin
            d = COORD_WIDTH'(0) + ({a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b});
            m = d[COORD_WIDTH] ? -d : d;
            m = m >> EDGE_SHIFT;
            edge_of = d[COORD_WIDTH] ? -EW'(m) : EW'(m);
        end
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i] = edge_of(i_a[i], i_b[i]);
            n_v[i] = edge_of(i_b[i], i_c[i]);
        end
        n_p[0] = PW'(r_u[1]) * PW'(r_v[2]);
        n_p[1] = PW'(r_u[2]) * PW'(r_v[1]);
        n_p[2] = PW'(r_u[2]) * PW'(r_v[0]);
        n_p[3] = PW'(r_u[0]) * PW'(r_v[2]);
        n_p[4] = PW'(r_u[0]) * PW'(r_v[1]);
        n_p[5] = PW'(r_u[1]) * PW'(r_v[0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
            r_v <= n_v;
            r_p <= n_p;
        end
    end

    always_comb begin
        o_cross[0] = CW'(r_p[0]) - CW'(r_p[1]);
        o_cross[1] = CW'(r_p[2]) - CW'(r_p[3]);
        o_cross[2] = CW'(r_p[4]) - CW'(r_p[5]);
    end

endmodule

// ===== src/qcn_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcn_norm
// Pipelined normalization of one cross product to a unit vector: magnitude
// alignment, sum of squares, a one-bit-per-stage square root and a
// one-bit-per-stage restoring divider for all three components at once.
// ----------------------------------------------------------------------------
module qcn_norm #(
    parameter int CW               = 34,
    parameter int NORMAL_FRAC_BITS = qcn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [qcn_pkg::CORNER_W-1:0]         i_corner,
    input  logic signed [CW-1:0]                 i_cross [3],
    output logic                                 o_valid,
    output logic [qcn_pkg::CORNER_W-1:0]         o_corner,
    output logic signed [qcn_pkg::OUT_W-1:0]     o_normal [3],
    output logic                                 o_degenerate
);

    localparam int MW   = qcn_pkg::MAG_W;
    localparam int SW   = qcn_pkg::SUM_W;
    localparam int RW   = qcn_pkg::ROOT_W;
    localparam int LW   = $clog2(CW + 1);
    // Quotient bits: m < 2^31, r >= 2^30, so q < 2^(FRAC+2).
    localparam int QB   = NORMAL_FRAC_BITS + 2;
    localparam int NW   = MW + NORMAL_FRAC_BITS + 1;
    // Saturation compares need room for the 16-bit limits.
    localparam int XW   = (QB + 1 > 17) ? QB + 1 : 17;

    typedef struct packed {
        logic                          valid;
        logic [qcn_pkg::CORNER_W-1:0]  corner;
        logic                          degen;
        logic [2:0]                    neg;
    } t_tag;

    // Stage A: magnitudes and bit length of the largest.
    t_tag                r_ta;
    logic [CW-1:0]       r_ma [3];
    logic [LW-1:0]       r_len;
    // Stage B: aligned magnitudes.
    t_tag                r_tb;
    logic [MW-1:0]       r_mb [3];
    // Stage C: squares.
    t_tag                r_tc;
    logic [MW-1:0]       r_mc [3];
    logic [2*MW-1:0]     r_sq [3];
    // Square root stages.
    t_tag                r_ts [RW+1];
    logic [MW-1:0]       r_ms [RW+1][3];
    logic [SW-1:0]       r_rem [RW+1];
    logic [RW-1:0]       r_root [RW+1];
    // Divider stages: one quotient bit per stage for each component.
    t_tag                r_td [QB+1];
    logic [RW-1:0]       r_den [QB+1];
    logic [NW:0]         r_num [QB+1][3];
    logic [QB-1:0]       r_q   [QB+1][3];
    // Output register.
    t_tag                r_to;
    logic [qcn_pkg::OUT_W-1:0] r_out [3];

    logic [CW-1:0] n_m [3];
    logic [CW-1:0] n_mx;
    logic [LW-1:0] n_len;

    always_comb begin
        n_mx = '0;
        for (int i = 0; i < 3; i++) begin
            n_m[i] = i_cross[i][CW-1] ? CW'(-i_cross[i]) : CW'(i_cross[i]);
        end
        n_mx = n_m[0] | n_m[1] | n_m[2];
        n_len = '0;
        for (int b = 0; b < CW; b++) begin
            if (n_mx[b]) n_len = LW'(b + 1);
        end
    end

    logic [MW-1:0] n_al [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_len > LW'(MW)) begin
                n_al[i] = MW'(r_ma[i] >> (r_len - LW'(MW)));
            end else begin
                n_al[i] = MW'({{MW{1'b0}}, r_ma[i]} << (LW'(MW) - r_len));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta.valid <= 1'b0;
            r_tb.valid <= 1'b0;
            r_tc.valid <= 1'b0;
            r_to.valid <= 1'b0;
        end else if (i_en) begin
            r_ta.valid  <= i_valid;
            r_ta.corner <= i_corner;
            r_ta.degen  <= (n_mx == '0);
            r_ta.neg    <= {i_cross[2][CW-1], i_cross[1][CW-1], i_cross[0][CW-1]};
            r_ma        <= n_m;
            r_len       <= n_len;
            r_tb        <= r_ta;
            r_mb        <= n_al;
            r_tc        <= r_tb;
            r_mc        <= r_mb;
            for (int i = 0; i < 3; i++) r_sq[i] <= r_mb[i] * r_mb[i];
            r_to        <= r_td[QB];
        end
    end

    // Square root: one result bit per stage, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts[0].valid <= 1'b0;
        end else if (i_en) begin
            r_ts[0]   <= r_tc;
            r_ms[0]   <= r_mc;
            r_rem[0]  <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int B = RW - 1 - k;
        logic [SW-1:0] trial;
        logic [SW-1:0] cand;
        always_comb begin
            cand  = (SW'(r_root[k]) << (B + 1)) | (SW'(1) << (2 * B));
            trial = r_rem[k] - cand;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ts[k+1].valid <= 1'b0;
            end else if (i_en) begin
                r_ts[k+1] <= r_ts[k];
                r_ms[k+1] <= r_ms[k];
                if (r_rem[k] >= cand) begin
                    r_rem[k+1]  <= trial;
                    r_root[k+1] <= r_root[k] | (RW'(1) << B);
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_td[0].valid <= 1'b0;
        end else if (i_en) begin
            r_td[0]  <= r_ts[RW];
            r_den[0] <= r_root[RW];
            for (int i = 0; i < 3; i++) begin
                r_num[0][i] <= (NW+1)'({r_ms[RW][i], {NORMAL_FRAC_BITS{1'b0}}})
                             + (NW+1)'(r_root[RW] >> 1);
                r_q[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int B = QB - 1 - k;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_td[k+1].valid <= 1'b0;
            end else if (i_en) begin
                r_td[k+1]  <= r_td[k];
                r_den[k+1] <= r_den[k];
                for (int i = 0; i < 3; i++) begin
                    if (r_num[k][i] >= ((NW+1+QB)'(r_den[k]) << B)) begin
                        r_num[k+1][i] <= (NW+1)'((NW+1+QB)'(r_num[k][i])
                                         - ((NW+1+QB)'(r_den[k]) << B));
                        r_q[k+1][i]   <= r_q[k][i] | (QB'(1) << B);
                    end else begin
                        r_num[k+1][i] <= r_num[k][i];
                        r_q[k+1][i]   <= r_q[k][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_td[QB].degen) begin
                    r_out[i] <= '0;
                end else if (r_td[QB].neg[i]) begin
                    r_out[i] <= (XW'(r_q[QB][i]) > XW'(32768)) ? 16'h8000
                              : 16'(-XW'(r_q[QB][i]));
                end else begin
                    r_out[i] <= (XW'(r_q[QB][i]) > XW'(32767)) ? 16'h7FFF
                              : 16'(r_q[QB][i]);
                end
            end
        end
    end

    assign o_valid      = r_to.valid;
    assign o_corner     = r_to.corner;
    assign o_degenerate = r_to.degen;
    always_comb begin
        for (int i = 0; i < 3; i++) o_normal[i] = $signed(r_out[i]);
    end

endmodule

// ===== src/qcn_checker.sv =====
`timescale 1ns / 1ps
`include "quad_corner_normals_macros.svh"
// ----------------------------------------------------------------------------
// qcn_checker
// Port-level checks on the result stream of the quad normal block.
// ----------------------------------------------------------------------------
module qcn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_corner,
    input logic signed [15:0] o_normal_x,
    input logic signed [15:0] o_normal_y,
    input logic signed [15:0] o_normal_z,
    input logic        o_degenerate,
    input logic        o_last
);

    // A stalled result keeps its corner.
    `QCN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_corner) && o_valid, "stalled result changed")
    // The last flag marks corner three only.
    `QCN_ASSERT_IMPL(a_last, i_clk, i_rst_n, o_valid, o_last == (o_corner == 2'd3), "last flag mismatch")
    // Degenerate results carry a zero vector.
    `QCN_ASSERT_IMPL(a_degen, i_clk, i_rst_n, o_valid && o_degenerate, o_normal_x == 16'sd0 && o_normal_y == 16'sd0 && o_normal_z == 16'sd0, "degenerate not zero")

endmodule

bind quad_corner_normals qcn_checker u_qcn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_corner     (o_corner),
    .o_normal_x   (o_normal_x),
    .o_normal_y   (o_normal_y),
    .o_normal_z   (o_normal_z),
    .o_degenerate (o_degenerate),
    .o_last       (o_last)
);
